### rtl/psb_pkg.sv
// Package for the posed shape world bounds block.
// Holds shape codes, register indexes and fixed-point constants; no dependencies.
package psb_pkg;

  typedef enum logic [2:0] {
    KIND_BOX      = 3'd0,
    KIND_CYLINDER = 3'd1,
    KIND_SPHERE   = 3'd2,
    KIND_MESH     = 3'd3
  } kind_t;

  localparam logic [0:0] REG_SCAN_HEIGHT = 1'b0;
  localparam logic [30:0] SCAN_HEIGHT_RST = 31'd65536;
  localparam logic signed [31:0] BAND_FLOOR = 32'sd66;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Rotation matrix magnitudes, Q1.30, each at most 1.0
  typedef logic [30:0] rmag_t [3][3];

endpackage

### rtl/psb_quat_stage.sv
// Quaternion products and rotation matrix magnitudes, two register stages.
// Depends on psb_pkg.
module psb_quat_stage (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] qw,
  input  logic signed [31:0] qx,
  input  logic signed [31:0] qy,
  input  logic signed [31:0] qz,
  output psb_pkg::rmag_t     rmag
);

  logic signed [63:0] prod [9];
  logic signed [33:0] pr   [9];
  logic signed [63:0] p_rnd [9];
  logic signed [36:0] r [3][3];
  logic signed [31:0] a [9];
  logic signed [31:0] b [9];

  assign a = '{qx, qy, qz, qx, qx, qy, qw, qw, qw};
  assign b = '{qx, qy, qz, qy, qz, qz, qx, qy, qz};

  // Multiply, round half up to Q2.30 and register
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod[k]  = a[k] * b[k];
      p_rnd[k] = prod[k] + 64'sd536870912;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) pr[k] <= p_rnd[k][63:30];
    end
  end

  // Form the matrix: xx yy zz xy xz yz wx wy wz
  always_comb begin
    logic signed [36:0] one;
    one = 37'sd1073741824;
    r[0][0] = one - 37'(2 * (37'(pr[1]) + 37'(pr[2])));
    r[0][1] = 37'(2 * (37'(pr[3]) - 37'(pr[8])));
    r[0][2] = 37'(2 * (37'(pr[4]) + 37'(pr[7])));
    r[1][0] = 37'(2 * (37'(pr[3]) + 37'(pr[8])));
    r[1][1] = one - 37'(2 * (37'(pr[0]) + 37'(pr[2])));
    r[1][2] = 37'(2 * (37'(pr[5]) - 37'(pr[6])));
    r[2][0] = 37'(2 * (37'(pr[4]) - 37'(pr[7])));
    r[2][1] = 37'(2 * (37'(pr[5]) + 37'(pr[6])));
    r[2][2] = one - 37'(2 * (37'(pr[0]) + 37'(pr[1])));
  end

  // Take magnitude and clamp to 1.0
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          logic [36:0] m;
          m = r[i][j][36] ? 37'(-r[i][j]) : 37'(r[i][j]);
          rmag[i][j] <= (m > 37'(psb_pkg::ONE_Q30)) ? psb_pkg::ONE_Q30 : m[30:0];
        end
      end
    end
  end

endmodule

### rtl/psb_extent_stage.sv
// Half-extent products, sums and saturated bounds, three register stages.
// Depends on psb_pkg.
module psb_extent_stage (
  input  logic               clk,
  input  logic               adv,
  input  psb_pkg::rmag_t     rmag,
  input  logic [31:0]        h [3],
  input  logic signed [31:0] pos [3],
  output logic signed [31:0] mn [3],
  output logic signed [31:0] mx [3]
);

  logic [62:0] prod [3][3];
  logic [64:0] sum_next [3];
  logic [33:0] e [3];
  logic signed [31:0] pos_d [3];

  // Multiply magnitudes by half-extents
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod[i][j] <= rmag[i][j] * h[j];
      end
    end
  end

  // Sum, round to Q16.16
  always_comb begin
    for (int i = 0; i < 3; i++)
      sum_next[i] = 65'(prod[i][0]) + 65'(prod[i][1]) + 65'(prod[i][2])
                  + 65'h4000_0000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e[i]     <= sum_next[i][64:31];
        pos_d[i] <= pos[i];
      end
    end
  end

  // Offset from position and saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [35:0] lo, hi;
        lo = 36'(pos_d[i]) - $signed({2'b00, e[i]});
        hi = 36'(pos_d[i]) + $signed({2'b00, e[i]});
        mn[i] <= (lo < -36'sd2147483648) ? 32'sh8000_0000 : lo[31:0];
        mx[i] <= (hi > 36'sd2147483647) ? 32'sh7FFF_FFFF : hi[31:0];
      end
    end
  end

endmodule

### rtl/posed_shape_world_bounds_top.sv
// Posed shape world bounds: AABB of a rotated, translated primitive.
// Throughput: one item per cycle unless a result transfer is stalled.
// Six register stages: two quaternion, three extent, one output; all advance together.
// Reset (rst, synchronous) clears valid bits and sets scan_height to 1.0 m.
// Depends on psb_pkg, psb_quat_stage, psb_extent_stage.
module posed_shape_world_bounds_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [30:0]        dim_x,
  input  logic [30:0]        dim_y,
  input  logic [30:0]        dim_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] min_x,
  output logic signed [31:0] min_y,
  output logic signed [31:0] min_z,
  output logic signed [31:0] max_x,
  output logic signed [31:0] max_y,
  output logic signed [31:0] max_z,
  output logic               supported,
  output logic               in_band
);

  localparam int Depth = 5;

  logic [30:0] scan_height;
  logic        adv;
  logic [Depth-1:0] vld;
  logic [Depth-1:0] sup;
  logic [31:0] h_pipe [2][3];
  logic signed [31:0] pos_pipe [3][3];
  logic [31:0] h_next [3];
  psb_pkg::rmag_t rmag;
  logic signed [31:0] mn [3];
  logic signed [31:0] mx [3];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? {1'b0, scan_height} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_height <= psb_pkg::SCAN_HEIGHT_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      scan_height <= pwdata[30:0];
    end
  end

  // Whole pipe advances unless output is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Select half-extents in Q16.17
  always_comb begin
    case (kind)
      psb_pkg::KIND_CYLINDER: h_next = '{{dim_x, 1'b0}, {dim_x, 1'b0}, {1'b0, dim_z}};
      psb_pkg::KIND_SPHERE:   h_next = '{{dim_x, 1'b0}, {dim_x, 1'b0}, {dim_x, 1'b0}};
      default:                h_next = '{{1'b0, dim_x}, {1'b0, dim_y}, {1'b0, dim_z}};
    endcase
  end

  // Control and side data travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sup         <= {sup[Depth-2:0], (kind <= psb_pkg::KIND_MESH)};
      h_pipe[0]   <= h_next;
      h_pipe[1]   <= h_pipe[0];
      pos_pipe[0] <= '{pos_x, pos_y, pos_z};
      pos_pipe[1] <= pos_pipe[0];
      pos_pipe[2] <= pos_pipe[1];
    end
  end

  psb_quat_stage u_quat (
    .clk  (clk),
    .adv  (adv),
    .qw   (quat_w),
    .qx   (quat_x),
    .qy   (quat_y),
    .qz   (quat_z),
    .rmag (rmag)
  );

  psb_extent_stage u_ext (
    .clk  (clk),
    .adv  (adv),
    .rmag (rmag),
    .h    (h_pipe[1]),
    .pos  (pos_pipe[2]),
    .mn   (mn),
    .mx   (mx)
  );

  // Output register: band test and zeroing for unsupported kinds
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logic s;
      s = sup[Depth-1];
      min_x     <= s ? mn[0] : '0;
      min_y     <= s ? mn[1] : '0;
      min_z     <= s ? mn[2] : '0;
      max_x     <= s ? mx[0] : '0;
      max_y     <= s ? mx[1] : '0;
      max_z     <= s ? mx[2] : '0;
      supported <= s;
      in_band   <= s && (mn[2] < $signed({1'b0, scan_height}))
                     && (mx[2] >= psb_pkg::BAND_FLOOR);
    end
  end

endmodule

### rtl/psb_checker.sv
// Port-level checker for posed_shape_world_bounds_top, bound to the top level.
// Depends on nothing else.
module psb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        supported,
  input logic        in_band,
  input logic [31:0] min_z,
  input logic [31:0] max_z
);

  // Input is held back only while an output transfer is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall)) else $error("stall without cause");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(min_z) && $stable(max_z)))
    else $error("stalled result changed");

  // In band implies supported
  a_band: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_band) |-> supported) else $error("in_band without support");

  // Supported bounds are ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && supported) |-> ($signed(min_z) <= $signed(max_z)))
    else $error("min above max");

endmodule

bind posed_shape_world_bounds_top psb_checker u_psb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .supported (supported),
  .in_band   (in_band),
  .min_z     (min_z),
  .max_z     (max_z)
);

### dv/psb_bounds_checker.sv
// Result checker for the posed shape world bounds block.
// Watches both transfer channels, predicts world bounds and compares; uses psb_pkg.
module psb_bounds_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [30:0]        cfg_height,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [30:0]        dim_x,
  input  logic [30:0]        dim_y,
  input  logic [30:0]        dim_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic signed [31:0] max_x,
  input  logic signed [31:0] max_y,
  input  logic signed [31:0] max_z,
  input  logic               supported,
  input  logic               in_band,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic               ok, band;
  } bounds_t;

  bounds_t    bounds_q[$];
  logic [30:0] band_top;

  // Q2.30 product, rounded half up
  function automatic longint qprod(longint a, longint b);
    longint p;
    p = a * b + (longint'(1) <<< 29);
    return p >>> 30;
  endfunction

  function automatic longint clamp_mag(longint r);
    longint m;
    m = (r < 0) ? -r : r;
    return (m > (longint'(1) << 30)) ? (longint'(1) << 30) : m;
  endfunction

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic bounds_t world_bounds(logic [2:0] k, logic [30:0] dx, dy, dz,
      logic signed [31:0] px, py, pz, qw, qx, qy, qz, logic [30:0] top);
    bounds_t b;
    longint h[3], pos[3], rot[3][3], e, lo[3], hi[3];
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
    longint unsigned acc;
    b = '0;
    if (k > psb_pkg::KIND_MESH) return b;
    // half extents in Q16.17: size as is, radius doubled
    case (k)
      psb_pkg::KIND_CYLINDER: begin h[0] = 2 * dx; h[1] = 2 * dx; h[2] = dz; end
      psb_pkg::KIND_SPHERE:   begin h[0] = 2 * dx; h[1] = 2 * dx; h[2] = 2 * dx; end
      default:                begin h[0] = dx; h[1] = dy; h[2] = dz; end
    endcase
    pos[0] = px; pos[1] = py; pos[2] = pz;
    one = longint'(1) << 30;
    xx = qprod(qx, qx); yy = qprod(qy, qy); zz = qprod(qz, qz);
    xy = qprod(qx, qy); xz = qprod(qx, qz); yz = qprod(qy, qz);
    wx = qprod(qw, qx); wy = qprod(qw, qy); wz = qprod(qw, qz);
    rot[0][0] = one - 2 * (yy + zz); rot[0][1] = 2 * (xy - wz); rot[0][2] = 2 * (xz + wy);
    rot[1][0] = 2 * (xy + wz); rot[1][1] = one - 2 * (xx + zz); rot[1][2] = 2 * (yz - wx);
    rot[2][0] = 2 * (xz - wy); rot[2][1] = 2 * (yz + wx); rot[2][2] = one - 2 * (xx + yy);
    for (int i = 0; i < 3; i++) begin
      acc = longint'(1) << 30;
      for (int j = 0; j < 3; j++) acc += clamp_mag(rot[i][j]) * h[j];
      e = longint'(acc >> 31);
      lo[i] = sat(pos[i] - e);
      hi[i] = sat(pos[i] + e);
    end
    b.lo_x = lo[0][31:0]; b.lo_y = lo[1][31:0]; b.lo_z = lo[2][31:0];
    b.hi_x = hi[0][31:0]; b.hi_y = hi[1][31:0]; b.hi_z = hi[2][31:0];
    b.ok   = 1'b1;
    b.band = (lo[2] < longint'(top)) && (hi[2] >= longint'(psb_pkg::BAND_FLOOR));
    return b;
  endfunction

  assign pending = bounds_q.size();

  always @(posedge clk) begin
    bounds_t want, got;
    if (rst) begin
      band_top   <= psb_pkg::SCAN_HEIGHT_RST;
      fail_count <= 0;
    end else begin
      if (cfg_wr) band_top <= cfg_height;
      // predict on each input transfer
      if (in_valid && !in_stall)
        bounds_q = {bounds_q, world_bounds(kind, dim_x, dim_y, dim_z, pos_x, pos_y, pos_z,
                                           quat_w, quat_x, quat_y, quat_z, band_top)};
      // compare each result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{min_x, min_y, min_z, max_x, max_y, max_z, supported, in_band};
        if (bounds_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = bounds_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10) $display("bounds mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### dv/tb.sv
// Testbench top for the posed shape world bounds block.
// Drives shapes and register writes, instantiates u_top and psb_bounds_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] kind;
  logic [30:0] dim_x, dim_y, dim_z;
  logic signed [31:0] pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0] min_x, min_y, min_z, max_x, max_y, max_z;
  logic supported, in_band;
  int fail_count, pending, idle_cycles;
  logic calm;

  localparam int ITEMS = 1100;
  localparam int WATCHDOG = 2000;
  localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

  posed_shape_world_bounds_top u_top (.*);

  psb_bounds_checker u_chk (
    .cfg_wr(psel && penable && pwrite && pready &&
            paddr == {psb_pkg::REG_SCAN_HEIGHT, 1'b0}),
    .cfg_height(pwdata[30:0]), .*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    out_stall = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(18, 1)) @(posedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  task automatic reg_write(logic [30:0] value);
    psel <= 1; pwrite <= 1; paddr <= {psb_pkg::REG_SCAN_HEIGHT, 1'b0};
    pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // one shape transfer; random gaps before it
  task automatic send_shape(logic [2:0] k, logic [30:0] dx, dy, dz,
                            logic signed [31:0] px, py, pz, qw, qx, qy, qz);
    if (!calm && $urandom_range(15) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_valid <= 1; kind <= k; dim_x <= dx; dim_y <= dy; dim_z <= dz;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_quat();
    case ($urandom_range(3))
      0: return $signed($urandom_range(32'h8000_0000)) - Q_ONE;
      1: return $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
      2: return $urandom_range(1) ? Q_ONE : -Q_ONE;
      default: return 0;
    endcase
  endfunction

  function automatic logic [30:0] rand_dim();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(32'h0004_0000));
      2: return $urandom_range(1) ? 31'h7fff_ffff : 31'd0;
      default: return 31'($urandom_range(255));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(2))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  initial begin
    logic [30:0] heights [4];
    logic [30:0] mx;
    rst = 1; calm = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; kind = 0; dim_x = 0; dim_y = 0; dim_z = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    mx = 31'h7fff_ffff;

    // directed: every kind, extremes, unused dims, non-unit and identity rotations
    for (int k = 0; k < 8; k++)
      send_shape(3'(k), 31'h0002_0000, 31'h0004_0000, 31'h0006_0000, 0, 0, 32'sh0000_8000,
                 Q_ONE, 0, 0, 0);
    send_shape(psb_pkg::KIND_BOX, mx, mx, mx, 32'sh7fff_ffff, 32'sh8000_0000,
               32'sh7fff_ffff, Q_ONE, 0, 0, 0);
    send_shape(psb_pkg::KIND_SPHERE, mx, mx, mx, 32'sh8000_0000, 0, 32'sh8000_0000,
               0, Q_ONE, 0, 0);
    send_shape(psb_pkg::KIND_CYLINDER, 31'h1_0000, mx, 31'h2_0000, 0, 0, 66, 0, 0, Q_ONE, 0);
    send_shape(psb_pkg::KIND_MESH, 31'd0, 31'd0, 31'd0, 0, 0, 65,
               -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
    send_shape(psb_pkg::KIND_BOX, 31'd1, 31'd1, 31'd1, 0, 0, 66, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    send_shape(psb_pkg::KIND_BOX, 31'h1_0000, 31'h1_0000, 31'h1_0000, -1, -1, 32'sh0001_0000,
               32'sh2d41_3ccd, 0, 0, 32'sh2d41_3ccd);
    send_shape(psb_pkg::KIND_MESH, 31'd0, 31'd0, 31'd0, 0, 0, 32'sh0000_ffff, 0, 0, 0, Q_ONE);
    drain();

    // random phases across band heights, extremes included
    heights = '{31'd0, 31'h7fff_ffff, 31'd66, 31'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(heights[ph]);
      if (ph == 3) calm = 1;
      for (int n = 0; n < ITEMS / 4; n++)
        send_shape(3'($urandom_range(7)), rand_dim(), rand_dim(), rand_dim(), rand_pos(),
                   rand_pos(), $urandom_range(3) == 0 ? rand_pos() :
                   $signed($urandom_range(32'h0003_0000)) - 32'sh0001_0000,
                   rand_quat(), rand_quat(), rand_quat(), rand_quat());
      drain();
    end

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
